// ===== hdl/trsl_pkg.sv =====
package trsl_pkg;

  // Field widths of the channel words, the registers and the hall counter.
  localparam int unsigned CODE_W  = 12;
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned DUTY_W  = 8;
  localparam int unsigned SCALE_W = 20;
  localparam int unsigned STEP_W  = 8;
  localparam int unsigned COUNT_W = 16;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE  = 3'd4;

  // Register values after reset.
  localparam logic [CODE_W-1:0]  RST_THROTTLE_MIN = 12'd0;
  localparam logic [CODE_W-1:0]  RST_THROTTLE_MAX = 12'd4095;
  localparam logic [SPEED_W-1:0] RST_SPEED_LIMIT  = 16'd50000;
  localparam logic [STEP_W-1:0]  RST_RAMP_STEP    = 8'd1;
  localparam logic [SCALE_W-1:0] RST_SPEED_SCALE  = 20'd254541;

  // Serial unit lengths: one multiplier bit or one quotient bit per cycle.
  localparam int unsigned MUL_STEPS = COUNT_W;
  localparam int unsigned DIV_STEPS = DUTY_W;
  localparam int unsigned STEP_CNT_W = $clog2(MUL_STEPS);

  typedef enum logic [1:0] {
    OP_HALL   = 2'd0,
    OP_WINDOW = 2'd1,
    OP_CTRL   = 2'd2,
    OP_SPARE  = 2'd3
  } trsl_op_t;

  typedef enum logic {
    KIND_SPEED = 1'b0,
    KIND_PWM   = 1'b1
  } trsl_kind_t;

  typedef struct packed {
    trsl_op_t          operation;
    logic [CODE_W-1:0] throttle_code;
    logic              brake_released;
  } trsl_in_word_t;

  typedef struct packed {
    trsl_kind_t         result_kind;
    logic [SPEED_W-1:0] speed_mh;
    logic [DUTY_W-1:0]  pwm_duty;
  } trsl_out_word_t;

endpackage

// ===== hdl/trsl_stream_if.sv =====
interface trsl_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== hdl/throttle_ramp_speed_limiter_unit.sv =====
// Channel   Dir  Word            Handshake
// in_word   in   trsl_in_word_t  valid/ready, taken when both are high
// out_word  out  trsl_out_word_t valid/ready, held until taken
// cfg_*     in   index + data    written on every edge with cfg_we high
//
// A hall edge is handled at the accept and gives no word. A window end takes
// the accept, 16 steps of a bit-serial shift-add multiplier and one to finish.
// A control tick takes the accept, 8 steps of a restoring divider and one to
// finish, or only the accept and the finish when the target is clamped.
// Reset (rst_n low, synchronous) clears the counters, speed, ramp and the
// handshake. A word waiting on out_word does not block the next input word;
// only finishing the following result waits for the output register.
module throttle_ramp_speed_limiter_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  trsl_stream_if.sink                      in_word,
  trsl_stream_if.source                    out_word,
  input  logic                             cfg_we,
  input  logic [trsl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [trsl_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import trsl_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_t;

  // Configuration registers.
  logic [CODE_W-1:0]  throttle_min_r;
  logic [CODE_W-1:0]  throttle_max_r;
  logic [SPEED_W-1:0] speed_limit_r;
  logic [STEP_W-1:0]  ramp_step_r;
  logic [SCALE_W-1:0] speed_scale_r;

  // Block state.
  state_t             state_r;
  trsl_op_t           op_r;
  logic               brake_rel_r;
  logic [STEP_CNT_W-1:0] step_cnt_r;
  logic [COUNT_W-1:0] pulse_count_r;
  logic [SPEED_W-1:0] speed_r;
  logic [DUTY_W-1:0]  ramp_r;

  // Serial datapath: product register, divider remainder and quotient.
  logic [SCALE_W+COUNT_W-1:0] prod_r;
  logic [CODE_W-1:0]          rem_r;
  logic [DUTY_W-1:0]          quo_r;

  // Output register.
  logic           out_valid_r;
  trsl_out_word_t out_data_r;

  logic accept;
  logic fin_fire;

  assign in_word.ready  = (state_r == ST_IDLE);
  assign accept         = in_word.valid && in_word.ready;
  assign fin_fire       = (state_r == ST_FIN) && (!out_valid_r || out_word.ready);
  assign out_word.valid = out_valid_r;
  assign out_word.data  = out_data_r;

  // Control tick setup: span, offset and offset * 255 as the dividend.
  logic                  code_low;
  logic                  code_high;
  logic [CODE_W-1:0]     offset;
  logic [CODE_W-1:0]     span;
  logic [CODE_W+DUTY_W-1:0] dividend;

  always_comb begin
    code_low  = (throttle_max_r <= throttle_min_r) ||
                (in_word.data.throttle_code <= throttle_min_r);
    code_high = (in_word.data.throttle_code >= throttle_max_r);
    offset    = in_word.data.throttle_code - throttle_min_r;
    span      = throttle_max_r - throttle_min_r;
    dividend  = {offset, {DUTY_W{1'b0}}} - {{DUTY_W{1'b0}}, offset};
  end

  // One multiplier step: add the scale when the low count bit is set.
  logic [SCALE_W:0] mul_sum;

  always_comb begin
    mul_sum = {1'b0, prod_r[SCALE_W+COUNT_W-1:COUNT_W]} +
              (prod_r[0] ? {1'b0, speed_scale_r} : '0);
  end

  // One divider step: shift in the next dividend bit and try the span.
  logic [CODE_W:0]   div_shift;
  logic [CODE_W+1:0] div_trial;
  logic              div_bit;

  always_comb begin
    div_shift = {rem_r, quo_r[DUTY_W-1]};
    div_trial = {1'b0, div_shift} - {2'b00, span};
    div_bit   = !div_trial[CODE_W+1];
  end

  // Window result: drop the Q8 fraction and saturate to 16 bits.
  logic [SPEED_W-1:0] speed_nxt;

  always_comb begin
    if (prod_r[SCALE_W+COUNT_W-1:SPEED_W+8] != '0) begin
      speed_nxt = '1;
    end else begin
      speed_nxt = prod_r[SPEED_W+7:8];
    end
  end

  // Ramp update: fall when over the limit, else rise or take the target.
  logic [DUTY_W:0]   ramp_up;
  logic [DUTY_W-1:0] ramp_nxt;

  always_comb begin
    ramp_up = {1'b0, ramp_r} + {1'b0, ramp_step_r};
    if (speed_r > speed_limit_r) begin
      ramp_nxt = (ramp_r > ramp_step_r) ? (ramp_r - ramp_step_r) : '0;
    end else if (ramp_r < quo_r) begin
      ramp_nxt = ramp_up[DUTY_W] ? '1 : ramp_up[DUTY_W-1:0];
    end else begin
      ramp_nxt = quo_r;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      throttle_min_r <= RST_THROTTLE_MIN;
      throttle_max_r <= RST_THROTTLE_MAX;
      speed_limit_r  <= RST_SPEED_LIMIT;
      ramp_step_r    <= RST_RAMP_STEP;
      speed_scale_r  <= RST_SPEED_SCALE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THROTTLE_MIN: throttle_min_r <= cfg_data[CODE_W-1:0];
        CFG_THROTTLE_MAX: throttle_max_r <= cfg_data[CODE_W-1:0];
        CFG_SPEED_LIMIT:  speed_limit_r  <= cfg_data[SPEED_W-1:0];
        CFG_RAMP_STEP:    ramp_step_r    <= cfg_data[STEP_W-1:0];
        CFG_SPEED_SCALE:  speed_scale_r  <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, serial units and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      op_r          <= OP_HALL;
      brake_rel_r   <= 1'b0;
      step_cnt_r    <= '0;
      pulse_count_r <= '0;
      speed_r       <= '0;
      ramp_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      // The output word leaves when taken, unless a new one replaces it.
      if (out_word.ready && !fin_fire) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            op_r        <= in_word.data.operation;
            brake_rel_r <= in_word.data.brake_released;
            step_cnt_r  <= '0;
            case (in_word.data.operation)
              OP_HALL: begin
                if (pulse_count_r != '1) begin
                  pulse_count_r <= pulse_count_r + 1'b1;
                end
              end
              OP_WINDOW: begin
                prod_r        <= {{SCALE_W{1'b0}}, pulse_count_r};
                pulse_count_r <= '0;
                state_r       <= ST_MUL;
              end
              OP_CTRL: begin
                if (code_low) begin
                  quo_r   <= '0;
                  state_r <= ST_FIN;
                end else if (code_high) begin
                  quo_r   <= '1;
                  state_r <= ST_FIN;
                end else begin
                  rem_r   <= dividend[CODE_W+DUTY_W-1:DUTY_W];
                  quo_r   <= dividend[DUTY_W-1:0];
                  state_r <= ST_DIV;
                end
              end
              default: ;
            endcase
          end
        end
        ST_MUL: begin
          prod_r     <= {mul_sum, prod_r[COUNT_W-1:1]};
          step_cnt_r <= step_cnt_r + 1'b1;
          if (step_cnt_r == STEP_CNT_W'(MUL_STEPS - 1)) begin
            state_r <= ST_FIN;
          end
        end
        ST_DIV: begin
          rem_r      <= div_bit ? div_trial[CODE_W-1:0] : div_shift[CODE_W-1:0];
          quo_r      <= {quo_r[DUTY_W-2:0], div_bit};
          step_cnt_r <= step_cnt_r + 1'b1;
          if (step_cnt_r == STEP_CNT_W'(DIV_STEPS - 1)) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_fire) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
            if (op_r == OP_WINDOW) begin
              speed_r                 <= speed_nxt;
              out_data_r.result_kind  <= KIND_SPEED;
              out_data_r.speed_mh     <= speed_nxt;
              out_data_r.pwm_duty     <= '0;
            end else begin
              out_data_r.result_kind  <= KIND_PWM;
              out_data_r.speed_mh     <= speed_r;
              if (brake_rel_r) begin
                ramp_r              <= ramp_nxt;
                out_data_r.pwm_duty <= ramp_nxt;
              end else begin
                out_data_r.pwm_duty <= '0;
              end
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // The count was cleared when the window word was taken, and no hall edge
  // can slip in while the multiplier runs.
  a_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && op_r == OP_WINDOW) |-> (pulse_count_r == '0))
    else $error("pulse count not clear at window end");

  // An engaged brake never moves the ramp.
  a_brake_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_fire && op_r == OP_CTRL && !brake_rel_r) |=> $stable(ramp_r))
    else $error("ramp moved with brake engaged");

  // Speed reports always carry a zero duty.
  a_speed_duty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.result_kind == KIND_SPEED) |-> (out_data_r.pwm_duty == '0))
    else $error("speed report with nonzero duty");
`endif

endmodule

// ===== tb/tb.sv =====
module tb;
  import trsl_pkg::*;

  localparam int unsigned RAND_ITEMS = 1030;
  localparam int unsigned SETTLE_CYC = 40;
  localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
  localparam logic [SPEED_W-1:0] SPEED_MAX = 16'hFFFF;

  // One row of the directed table: either a register write or an input word.
  typedef struct packed {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    trsl_in_word_t         w;
    bit                    typed;
    trsl_out_word_t        want;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  trsl_stream_if #(.payload_t(trsl_in_word_t))  in_ch ();
  trsl_stream_if #(.payload_t(trsl_out_word_t)) out_ch ();

  throttle_ramp_speed_limiter_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_ch),
    .out_word (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Shadow copy of the limiter: registers and state.
  logic [CODE_W-1:0]  thr_min;
  logic [CODE_W-1:0]  thr_max;
  logic [SPEED_W-1:0] limit_mh;
  logic [STEP_W-1:0]  step_sz;
  logic [SCALE_W-1:0] scale_q8;
  logic [COUNT_W-1:0] hall_count;
  logic [SPEED_W-1:0] speed_now;
  logic [DUTY_W-1:0]  ramp_duty;

  trsl_out_word_t pending_words[$];
  stim_row_t      dir_rows[$];
  int             mismatch_cnt;
  int             rand_items;
  int             in_calm;
  bit             gaps_on;
  bit             stalls_on;
  bit             typed_on;
  trsl_out_word_t typed_word;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb: done, errors");
    $finish;
  end

  // Throttle sample mapped onto the 0..255 duty range.
  function automatic logic [DUTY_W-1:0] throttle_to_target(input logic [CODE_W-1:0] code);
    logic [19:0] num;
    logic [19:0] span;
    if (thr_max <= thr_min || code <= thr_min) return '0;
    if (code >= thr_max) return DUTY_MAX;
    span = {8'b0, thr_max - thr_min};
    num = {8'b0, code - thr_min} * 20'd255;
    return 8'(num / span);
  endfunction

  // Applies one accepted input word; returns 1 when it yields an output word.
  function automatic bit advance_limiter(input trsl_in_word_t w, output trsl_out_word_t r);
    logic [35:0]       prod;
    logic [8:0]        sum;
    logic [DUTY_W-1:0] tgt;
    r = '0;
    case (w.operation)
      OP_HALL: begin
        if (hall_count != COUNT_MAX) hall_count = hall_count + 1'b1;
        return 1'b0;
      end
      OP_WINDOW: begin
        prod = ({20'b0, hall_count} * {16'b0, scale_q8}) >> 8;
        speed_now = (prod > {20'b0, SPEED_MAX}) ? SPEED_MAX : prod[SPEED_W-1:0];
        hall_count = '0;
        r.result_kind = KIND_SPEED;
        r.speed_mh = speed_now;
        return 1'b1;
      end
      OP_CTRL: begin
        tgt = throttle_to_target(w.throttle_code);
        r.result_kind = KIND_PWM;
        r.speed_mh = speed_now;
        if (w.brake_released) begin
          if (speed_now > limit_mh) begin
            ramp_duty = (ramp_duty > step_sz) ? ramp_duty - step_sz : '0;
          end else if (ramp_duty < tgt) begin
            sum = {1'b0, ramp_duty} + {1'b0, step_sz};
            ramp_duty = sum[8] ? DUTY_MAX : sum[7:0];
          end else begin
            ramp_duty = tgt;
          end
          r.pwm_duty = ramp_duty;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic stim_row_t word_row(input trsl_op_t op, input logic [CODE_W-1:0] code,
                                         input logic rel);
    stim_row_t r;
    r = '0;
    r.w.operation = op;
    r.w.throttle_code = code;
    r.w.brake_released = rel;
    return r;
  endfunction

  function automatic stim_row_t checked_row(input trsl_op_t op, input logic [CODE_W-1:0] code,
                                            input logic rel, input trsl_kind_t kind,
                                            input logic [SPEED_W-1:0] spd,
                                            input logic [DUTY_W-1:0] duty);
    stim_row_t r;
    r = word_row(op, code, rel);
    r.typed = 1'b1;
    r.want.result_kind = kind;
    r.want.speed_mh = spd;
    r.want.pwm_duty = duty;
    return r;
  endfunction

  function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
    stim_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  // Sends one word, with an occasional idle burst ahead of it. Called and
  // returns at a falling edge; valid stays high until the next call decides.
  task automatic send_word(input trsl_in_word_t w, input bit typed,
                           input trsl_out_word_t want);
    int pick;
    pick = $urandom_range(0, 15);
    if (in_calm > 0) begin
      in_calm--;
    end else if (gaps_on && pick == 0) begin
      in_calm = $urandom_range(10, 80);
    end else if (gaps_on && pick < 5) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    typed_on <= typed;
    typed_word <= want;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Register write once the block has gone quiet; the shadow copy follows.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_THROTTLE_MIN: thr_min = val[CODE_W-1:0];
      CFG_THROTTLE_MAX: thr_max = val[CODE_W-1:0];
      CFG_SPEED_LIMIT:  limit_mh = val[SPEED_W-1:0];
      CFG_RAMP_STEP:    step_sz = val[STEP_W-1:0];
      CFG_SPEED_SCALE:  scale_q8 = val[SCALE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random word of the given kind, now and then swapped for any operation.
  task automatic send_item(input trsl_op_t op);
    trsl_in_word_t w;
    w.operation = op;
    if ($urandom_range(0, 11) == 0) w.operation = trsl_op_t'($urandom_range(0, 3));
    if (thr_min < thr_max && $urandom_range(0, 1) == 1)
      w.throttle_code = CODE_W'($urandom_range(thr_min, thr_max));
    else
      w.throttle_code = CODE_W'($urandom_range(0, 4095));
    w.brake_released = ($urandom_range(0, 4) != 0);
    if (w.operation != OP_SPARE) rand_items++;
    send_word(w, 1'b0, '0);
  endtask

  // New setting for every register, the extremes among the choices.
  task automatic random_config();
    logic [CODE_W-1:0] a;
    logic [CODE_W-1:0] b;
    logic [CODE_W-1:0] lo;
    logic [CODE_W-1:0] hi;
    a = CODE_W'($urandom_range(0, 4095));
    b = CODE_W'($urandom_range(0, 4095));
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    case ($urandom_range(0, 9))
      0: begin write_reg(CFG_THROTTLE_MIN, 0); write_reg(CFG_THROTTLE_MAX, 4095); end
      1: begin
        write_reg(CFG_THROTTLE_MIN, CFG_DATA_W'(a));
        write_reg(CFG_THROTTLE_MAX, CFG_DATA_W'(a));
      end
      2: begin
        write_reg(CFG_THROTTLE_MIN, CFG_DATA_W'(hi));
        write_reg(CFG_THROTTLE_MAX, CFG_DATA_W'(lo));
      end
      default: begin
        write_reg(CFG_THROTTLE_MIN, CFG_DATA_W'(lo));
        write_reg(CFG_THROTTLE_MAX, CFG_DATA_W'(hi));
      end
    endcase
    case ($urandom_range(0, 5))
      0: write_reg(CFG_SPEED_LIMIT, 0);
      1: write_reg(CFG_SPEED_LIMIT, 50000);
      2: write_reg(CFG_SPEED_LIMIT, 65535);
      default: write_reg(CFG_SPEED_LIMIT, CFG_DATA_W'($urandom_range(0, 60000)));
    endcase
    case ($urandom_range(0, 7))
      0: write_reg(CFG_RAMP_STEP, 0);
      1: write_reg(CFG_RAMP_STEP, 1);
      2: write_reg(CFG_RAMP_STEP, 255);
      default: write_reg(CFG_RAMP_STEP, CFG_DATA_W'($urandom_range(1, 64)));
    endcase
    case ($urandom_range(0, 5))
      0: write_reg(CFG_SPEED_SCALE, 0);
      1: write_reg(CFG_SPEED_SCALE, 1048575);
      2: write_reg(CFG_SPEED_SCALE, 254541);
      default: write_reg(CFG_SPEED_SCALE, CFG_DATA_W'($urandom_range(0, 400000)));
    endcase
  endtask

  // Result-side back pressure: short stall bursts between calm stretches.
  initial begin
    int stall_left;
    int calm_left;
    out_ch.ready = 1'b0;
    stall_left = 0;
    calm_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (calm_left > 0) begin
          calm_left--;
        end else if (stalls_on) begin
          case ($urandom_range(0, 15))
            0: calm_left = $urandom_range(20, 150);
            1, 2, 3: stall_left = $urandom_range(1, 4);
            default: ;
          endcase
        end
      end
    end
  end

  // Predict on every accepted input word, check every accepted output word.
  always @(posedge clk) begin
    trsl_out_word_t pred;
    trsl_out_word_t want;
    trsl_out_word_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        if (advance_limiter(in_ch.data, pred))
          pending_words.push_back(typed_on ? typed_word : pred);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (pending_words.size() == 0) begin
          $display("%0t: unexpected word, expected none, got kind %0d speed %0d duty %0d",
                   $time, got.result_kind, got.speed_mh, got.pwm_duty);
          mismatch_cnt++;
        end else begin
          want = pending_words.pop_front();
          if (got.result_kind != want.result_kind) begin
            $display("%0t: result_kind expected %0d got %0d",
                     $time, want.result_kind, got.result_kind);
            mismatch_cnt++;
          end
          if (got.speed_mh != want.speed_mh) begin
            $display("%0t: speed_mh expected %0d got %0d", $time, want.speed_mh, got.speed_mh);
            mismatch_cnt++;
          end
          if (got.pwm_duty != want.pwm_duty) begin
            $display("%0t: pwm_duty expected %0d got %0d", $time, want.pwm_duty, got.pwm_duty);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  initial begin
    int nseq;
    int nhall;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    typed_on = 1'b0;
    typed_word = '0;
    mismatch_cnt = 0;
    rand_items = 0;
    in_calm = 0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    thr_min = RST_THROTTLE_MIN;
    thr_max = RST_THROTTLE_MAX;
    limit_mh = RST_SPEED_LIMIT;
    step_sz = RST_RAMP_STEP;
    scale_q8 = RST_SPEED_SCALE;
    hall_count = '0;
    speed_now = '0;
    ramp_duty = '0;

    // Directed part: reset values, over and at the limit, full ramp steps,
    // inverted and equal calibration, zero step, the unused operation.
    dir_rows = '{
      checked_row(OP_WINDOW, 0, 1'b1, KIND_SPEED, 0, 0),
      checked_row(OP_CTRL, 4095, 1'b1, KIND_PWM, 0, 1),
      checked_row(OP_CTRL, 0, 1'b0, KIND_PWM, 0, 0),
      word_row(OP_SPARE, 4095, 1'b1),
      word_row(OP_CTRL, 2048, 1'b1),
      word_row(OP_HALL, 0, 1'b0),
      word_row(OP_WINDOW, 4095, 1'b0),
      reg_row(CFG_SPEED_SCALE, 1048575),
      reg_row(CFG_SPEED_LIMIT, 0),
      reg_row(CFG_RAMP_STEP, 255),
      word_row(OP_HALL, 4095, 1'b1),
      checked_row(OP_WINDOW, 0, 1'b1, KIND_SPEED, 4095, 0),
      word_row(OP_CTRL, 4095, 1'b1),
      reg_row(CFG_SPEED_LIMIT, 65535),
      checked_row(OP_CTRL, 4095, 1'b1, KIND_PWM, 4095, 255),
      word_row(OP_CTRL, 4095, 1'b1),
      reg_row(CFG_THROTTLE_MIN, 4095),
      reg_row(CFG_THROTTLE_MAX, 0),
      word_row(OP_CTRL, 4095, 1'b1),
      reg_row(CFG_THROTTLE_MIN, 1000),
      reg_row(CFG_THROTTLE_MAX, 3000),
      reg_row(CFG_RAMP_STEP, 7),
      word_row(OP_CTRL, 2999, 1'b1),
      word_row(OP_CTRL, 3000, 1'b0),
      reg_row(CFG_RAMP_STEP, 0),
      word_row(OP_CTRL, 2000, 1'b1),
      word_row(OP_CTRL, 1010, 1'b1),
      word_row(OP_CTRL, 1000, 1'b1),
      reg_row(CFG_THROTTLE_MIN, 2000),
      reg_row(CFG_THROTTLE_MAX, 2000),
      word_row(OP_CTRL, 3000, 1'b1),
      reg_row(CFG_SPEED_LIMIT, 4095),
      word_row(OP_CTRL, 4095, 1'b1),
      word_row(OP_HALL, 0, 1'b1),
      word_row(OP_WINDOW, 0, 1'b0),
      word_row(OP_CTRL, 0, 1'b1)
    };

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg)
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      else
        send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random part: bursts of hall edges closed by a window, then control ticks.
    while (rand_items < RAND_ITEMS) begin
      if (rand_items > RAND_ITEMS - 150) begin
        gaps_on = 1'b0;
        stalls_on = 1'b0;
      end
      random_config();
      nseq = $urandom_range(1, 6);
      repeat (nseq) begin
        nhall = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 80) : $urandom_range(0, 20);
        repeat (nhall) send_item(OP_HALL);
        send_item(OP_WINDOW);
        repeat ($urandom_range(1, 8)) send_item(OP_CTRL);
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
    if (mismatch_cnt == 0 && pending_words.size() == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
